### hdl/two_level_page_table_engine_unit_macros.svh
// Assertion macros shared by the page table engine RTL.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_UNIT_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define TLPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tlpt_pkg.sv
// Types and constants of the two-level page table engine.
`default_nettype none
package tlpt_pkg;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned OFF_W       = 12;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned TBL_ENTRIES = 1024;

  localparam logic [1:0] MODE_MAP   = 2'd0;
  localparam logic [1:0] MODE_UNMAP = 2'd1;
  localparam logic [1:0] MODE_XLATE = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_XLATE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
  } in_t;

  typedef struct packed {
    logic [31:0] translated_addr;
    logic        hit;
    logic        pool_full;
  } out_t;

endpackage
`default_nettype wire

### hdl/tlpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tlpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/two_level_page_table_engine_unit.sv
// Two-level page table engine: directory RAM, table pool RAM and walk control.
// After reset the engine sweeps both RAMs to zero, one entry per cycle, with
// in_ready low, until all NUM_TABLES*1024 pool entries are clear. It then
// handles one operation at a time: map, unmap and the unused mode pass from the
// accepting cycle to a walk step that loads the result register; translate
// with a present directory entry goes on to a step that reads the table RAM and
// loads the result there, else it ends in the walk step. The dependent reads of
// the directory RAM and then the table RAM, each with registered read data, set
// these steps. A new item is accepted while the previous result still waits in
// the output register; the engine holds its final step only if that register is
// still full and out_ready is low when it finishes.
`default_nettype none
module two_level_page_table_engine_unit #(
  parameter int unsigned NUM_TABLES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tlpt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tlpt_pkg::out_t      out_data
);

  `include "two_level_page_table_engine_unit_macros.svh"

  localparam int unsigned TW        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned UW        = $clog2(NUM_TABLES + 1);
  localparam int unsigned ENT_DEPTH = NUM_TABLES * tlpt_pkg::TBL_ENTRIES;
  localparam int unsigned EAW       = $clog2(ENT_DEPTH);
  localparam int unsigned DAW       = tlpt_pkg::IDX_W;
  localparam int unsigned DW        = TW + 1;
  localparam int unsigned EW        = tlpt_pkg::FRAME_W + 1;

  tlpt_pkg::state_t state_r, state_nxt;
  logic [EAW-1:0]   clr_r;
  logic [UW-1:0]    used_r;
  logic [1:0]       mode_r;
  logic [31:0]      va_r;
  logic [31:0]      pa_r;
  logic             out_valid_r;
  tlpt_pkg::out_t   out_data_r;

  logic             dir_we, dir_re;
  logic [DAW-1:0]   dir_waddr, dir_raddr;
  logic [DW-1:0]    dir_wdata, dir_rdata;
  logic             ent_we, ent_re;
  logic [EAW-1:0]   ent_addr, ent_waddr;
  logic [EW-1:0]    ent_wdata, ent_rdata;

  logic             accept, push, used_inc, slot_free, dir_pres, pool_empty;
  logic [TW-1:0]    dir_tidx, new_tidx, sel_tidx;
  tlpt_pkg::out_t   res;

  tlpt_ram #(.WIDTH(DW), .DEPTH(tlpt_pkg::DIR_ENTRIES)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.WIDTH(EW), .DEPTH(ENT_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_addr),
    .rdata (ent_rdata)
  );

  assign in_ready   = (state_r == tlpt_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign dir_pres   = dir_rdata[TW];
  assign dir_tidx   = dir_rdata[TW-1:0];
  assign new_tidx   = TW'(used_r);
  assign pool_empty = (used_r == UW'(NUM_TABLES));
  assign sel_tidx   = dir_pres ? dir_tidx : new_tidx;
  assign ent_addr   = EAW'({sel_tidx, va_r[tlpt_pkg::OFF_W +: tlpt_pkg::IDX_W]});
  assign dir_raddr  = in_data.virt_addr[31 -: tlpt_pkg::IDX_W];

  always_comb begin
    state_nxt = state_r;
    dir_re    = accept;
    dir_we    = 1'b0;
    dir_waddr = va_r[31 -: tlpt_pkg::IDX_W];
    dir_wdata = {1'b1, new_tidx};
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = ent_addr;
    ent_wdata = '0;
    used_inc  = 1'b0;
    push      = 1'b0;
    res       = '0;
    case (state_r)
      tlpt_pkg::ST_CLEAR: begin
        // zero both RAMs; the directory covers only the low part of the sweep
        dir_we    = ({1'b0, clr_r} < (EAW+1)'(tlpt_pkg::DIR_ENTRIES));
        dir_waddr = clr_r[DAW-1:0];
        dir_wdata = '0;
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        if (clr_r == EAW'(ENT_DEPTH - 1)) begin
          state_nxt = tlpt_pkg::ST_IDLE;
        end
      end
      tlpt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tlpt_pkg::ST_WALK;
        end
      end
      tlpt_pkg::ST_WALK: begin
        case (mode_r)
          tlpt_pkg::MODE_MAP: begin
            if (slot_free) begin
              push      = 1'b1;
              state_nxt = tlpt_pkg::ST_IDLE;
              if (!dir_pres && pool_empty) begin
                res.pool_full = 1'b1;
              end else begin
                dir_we    = !dir_pres;
                used_inc  = !dir_pres;
                ent_we    = 1'b1;
                ent_wdata = {1'b1, pa_r[31 -: tlpt_pkg::FRAME_W]};
              end
            end
          end
          tlpt_pkg::MODE_UNMAP: begin
            if (slot_free) begin
              push      = 1'b1;
              ent_we    = dir_pres;
              state_nxt = tlpt_pkg::ST_IDLE;
            end
          end
          tlpt_pkg::MODE_XLATE: begin
            if (dir_pres) begin
              ent_re    = 1'b1;
              state_nxt = tlpt_pkg::ST_XLATE;
            end else if (slot_free) begin
              push      = 1'b1;
              state_nxt = tlpt_pkg::ST_IDLE;
            end
          end
          default: begin
            if (slot_free) begin
              push      = 1'b1;
              state_nxt = tlpt_pkg::ST_IDLE;
            end
          end
        endcase
      end
      tlpt_pkg::ST_XLATE: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = tlpt_pkg::ST_IDLE;
          if (ent_rdata[tlpt_pkg::FRAME_W]) begin
            res.hit             = 1'b1;
            res.translated_addr = {ent_rdata[tlpt_pkg::FRAME_W-1:0],
                                   va_r[tlpt_pkg::OFF_W-1:0]};
          end
        end
      end
      default: begin
        state_nxt = tlpt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpt_pkg::ST_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlpt_pkg::ST_CLEAR) begin
        clr_r <= clr_r + EAW'(1);
      end
      if (used_inc) begin
        used_r <= used_r + UW'(1);
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_data.mode;
      va_r   <= in_data.virt_addr;
      pa_r   <= in_data.phys_addr;
    end
    if (push) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TLPT_ASSERT_SAME(a_pool_bound, 1'b1, used_r <= UW'(NUM_TABLES), "pool count overran")
  `TLPT_ASSERT_SAME(a_full_ok, out_valid_r && out_data_r.pool_full, pool_empty, "early full")
  `TLPT_ASSERT_NEXT(a_accept_walks, accept, state_r == tlpt_pkg::ST_WALK, "no walk")
  `TLPT_ASSERT_SAME(a_hit_ok, out_valid_r && out_data_r.hit, !out_data_r.pool_full, "hit+full")

endmodule
`default_nettype wire

### tb/two_level_page_table_engine_unit_tb.sv
// Self-checking testbench for the two-level page table engine: map, unmap and translate traffic.
module two_level_page_table_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_TABLES = 16;
  localparam logic [1:0]  MODE_SPARE = 2'd3;
  localparam int unsigned RANDOM_OPS = 1150;
  // Clearing pass plus every item at its slowest, several times over.
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    tlpt_pkg::in_t item;
    int unsigned   gap;
    bit            drain;
  } queued_op_t;

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  tlpt_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tlpt_pkg::out_t out_data;

  queued_op_t     ops_to_send[$];
  tlpt_pkg::out_t expected_walks[$];
  int unsigned ops_queued   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned gap_count    = 0;
  int unsigned ready_wait   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  logic        in_taken     = 1'b0;
  logic        out_taken    = 1'b0;

  // Shadow page tables.
  logic dir_valid [tlpt_pkg::DIR_ENTRIES] = '{default: 1'b0};
  int unsigned dir_slot [tlpt_pkg::DIR_ENTRIES] = '{default: 0};
  logic [tlpt_pkg::TBL_ENTRIES-1:0] pte_valid [NUM_TABLES] = '{default: '0};
  logic [tlpt_pkg::FRAME_W-1:0] pte_frame [NUM_TABLES][tlpt_pkg::TBL_ENTRIES];
  int unsigned slots_taken = 0;

  two_level_page_table_engine_unit #(
    .NUM_TABLES(NUM_TABLES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic tlpt_pkg::out_t walk_page_tables(tlpt_pkg::in_t op);
    tlpt_pkg::out_t             res;
    logic [tlpt_pkg::IDX_W-1:0] di;
    logic [tlpt_pkg::IDX_W-1:0] ti;
    int unsigned                slot;
    res = '0;
    di  = op.virt_addr[31:22];
    ti  = op.virt_addr[21:12];
    case (op.mode)
      tlpt_pkg::MODE_MAP: begin
        if (!dir_valid[di] && slots_taken >= NUM_TABLES) begin
          res.pool_full = 1'b1;
        end else begin
          if (!dir_valid[di]) begin
            // Hand out the next table with an empty row.
            pte_valid[slots_taken] = '0;
            dir_slot[di]  = slots_taken;
            dir_valid[di] = 1'b1;
            slots_taken++;
          end
          slot = dir_slot[di];
          pte_valid[slot][ti] = 1'b1;
          pte_frame[slot][ti] = op.phys_addr[31:12];
        end
      end
      tlpt_pkg::MODE_UNMAP: begin
        if (dir_valid[di]) begin
          slot = dir_slot[di];
          pte_valid[slot][ti] = 1'b0;
          pte_frame[slot][ti] = '0;
        end
      end
      tlpt_pkg::MODE_XLATE: begin
        if (dir_valid[di]) begin
          slot = dir_slot[di];
          if (pte_valid[slot][ti]) begin
            res.hit = 1'b1;
            res.translated_addr = {pte_frame[slot][ti],
                                   op.virt_addr[tlpt_pkg::OFF_W-1:0]};
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: result %0d %s: got %h, want %h", $realtime, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  task automatic push_op(logic [1:0] mode, logic [31:0] va, logic [31:0] pa, bit drain);
    queued_op_t op;
    op.item.mode      = mode;
    op.item.virt_addr = va;
    op.item.phys_addr = pa;
    // Back-to-back stretch in the middle of the run.
    op.gap   = (ops_queued >= 700 && ops_queued < 900) ? 0 : $urandom_range(0, 6);
    op.drain = drain;
    ops_to_send.push_back(op);
    ops_queued++;
  endtask

  // Sample both channels; compare before predicting since a result never
  // belongs to the beat accepted on the same edge.
  always @(posedge clk) begin
    tlpt_pkg::out_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_walks.size() == 0) begin
        report_mismatch("unexpected beat", out_data.translated_addr, '0);
      end else begin
        want = expected_walks.pop_front();
        if (out_data.translated_addr !== want.translated_addr)
          report_mismatch("translated_addr", out_data.translated_addr, want.translated_addr);
        if (out_data.hit !== want.hit)
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
        if (out_data.pool_full !== want.pool_full)
          report_mismatch("pool_full", 32'(out_data.pool_full), 32'(want.pool_full));
      end
      results_seen <= results_seen + 1;
    end
    if (rst_n && in_valid && in_ready) begin
      expected_walks.push_back(walk_page_tables(in_data));
    end
  end

  // Long receiver hold-off, so the engine backs up and drops in_ready.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Sender: present the next beat once the previous one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (ops_to_send.size() != 0 && gap_count >= ops_to_send[0].gap &&
          !(ops_to_send[0].drain && expected_walks.size() != 0)) begin
        in_data   <= ops_to_send[0].item;
        in_valid  <= 1'b1;
        gap_count = 0;
        void'(ops_to_send.pop_front());
      end else begin
        in_valid <= 1'b0;
        if (ops_to_send.size() != 0) gap_count++;
      end
    end
  end

  // Receiver: random stall after each beat, none in a quiet window.
  always @(negedge clk) begin
    if (out_taken) begin
      ready_wait = (results_seen >= 600 && results_seen < 800) ? 0 : $urandom_range(0, 6);
    end else if (ready_wait != 0) begin
      ready_wait--;
    end
    out_ready <= rst_n && ready_wait == 0 && hold_left == 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned                n;
    int unsigned                r;
    int unsigned                pick;
    logic [tlpt_pkg::IDX_W-1:0] dir;
    logic [tlpt_pkg::IDX_W-1:0] tbl;
    logic [1:0]                 mode;
    logic [31:0]                va;

    // Directed: remap, misses, unused mode, unmap cases, then exhaust the pool.
    push_op(tlpt_pkg::MODE_MAP,   32'h0000_0000, 32'hFFFF_F000, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, 32'h0000_0FFF, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_MAP,   32'h0000_0000, 32'h0000_1ABC, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, 32'h0000_0123, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_UNMAP, 32'h0040_0000, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, 32'h0040_0000, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, 32'h0000_1000, 32'h0000_0000, 1'b0);
    push_op(MODE_SPARE,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_op(tlpt_pkg::MODE_UNMAP, 32'h0000_1000, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_UNMAP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    for (n = 1; n <= 14; n++) begin
      push_op(tlpt_pkg::MODE_MAP, {10'(n), 10'(n * 3), 12'h000}, $urandom(), 1'b0);
    end
    push_op(tlpt_pkg::MODE_MAP,   {10'd15, 10'd0, 12'h000}, 32'h1234_5000, 1'b0);
    push_op(tlpt_pkg::MODE_XLATE, {10'd15, 10'd0, 12'h000}, 32'h0000_0000, 1'b0);

    // Random: mostly hit the live directory entries and a few table slots.
    for (n = 0; n < RANDOM_OPS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      mode = tlpt_pkg::MODE_MAP;
      else if (r < 50) mode = tlpt_pkg::MODE_UNMAP;
      else if (r < 95) mode = tlpt_pkg::MODE_XLATE;
      else             mode = MODE_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 5)       dir = 10'd1023;
      else if (pick < 78) dir = 10'($urandom_range(0, 14));
      else                dir = 10'($urandom_range(15, 1022));
      tbl = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(0, 31));
      va  = ($urandom_range(0, 9) == 0) ? $urandom() : {dir, tbl, 12'($urandom())};
      push_op(mode, va, $urandom(), n == 500 || n == 1000);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_walks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
